>>> rtl/ppem_pkg.sv
// Shared types and constants for the printer pass-through exit matcher.
`default_nettype none

package ppem_pkg;

  localparam logic [7:0] B_NUL  = 8'h00;
  localparam logic [7:0] B_XON  = 8'h11;
  localparam logic [7:0] B_XOFF = 8'h13;
  localparam logic [7:0] B_ESC  = 8'h1B;
  localparam logic [7:0] B_CSI  = 8'h9B;
  localparam logic [7:0] B_LBR  = 8'h5B;
  localparam logic [7:0] B_FIVE = 8'h35;
  localparam logic [7:0] B_FOUR = 8'h34;
  localparam logic [7:0] B_LI   = 8'h69;

  localparam int unsigned NumSeq  = 4;
  localparam int unsigned MaxHeld = 3;

  // sequence n, byte i at [n][i]
  localparam logic [3:0][3:0][7:0] SEQ_BYTES = {
    {B_LI,   B_FOUR, B_LBR,  B_ESC},
    {B_LI,   B_FIVE, B_LBR,  B_ESC},
    {B_NUL,  B_LI,   B_FOUR, B_CSI},
    {B_NUL,  B_LI,   B_FIVE, B_CSI}
  };
  localparam logic [3:0][2:0] SEQ_LEN  = {3'd4, 3'd4, 3'd3, 3'd3};
  localparam logic [3:0]      SEQ_STAY = 4'b0101;

  typedef struct packed {
    logic            mode;
    logic            stay;
    logic            close;
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/ppem_front.sv
// Front end: accept a byte, match it against the exit sequences, keep the held bytes.
`default_nettype none

module ppem_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic          in_valid_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output ppem_pkg::cmd_t     cmd_o
);

  logic                  auto_close_q;
  logic [2:0][7:0]       held_q, held_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  accept;
  logic                  is_drop;
  logic                  is_cand;
  logic [3:0][7:0]       buf_bytes;
  logic [2:0]            len;
  logic [3:0]            complete;
  logic [3:0]            extend;
  logic                  stay;

  assign accept = in_valid_i && !q_full_i;

  always_comb begin
    is_drop = (rx_byte_i == ppem_pkg::B_NUL) || (rx_byte_i == ppem_pkg::B_XON) ||
              (rx_byte_i == ppem_pkg::B_XOFF);
    is_cand = rx_byte_i inside {ppem_pkg::B_CSI, ppem_pkg::B_ESC, ppem_pkg::B_LBR,
                                ppem_pkg::B_FOUR, ppem_pkg::B_FIVE, ppem_pkg::B_LI};
    for (int i = 0; i < ppem_pkg::MaxHeld; i++) begin
      buf_bytes[i] = (2'(i) < cnt_q) ? held_q[i] : rx_byte_i;
    end
    buf_bytes[3] = rx_byte_i;
    len = {1'b0, cnt_q} + 3'd1;
    for (int n = 0; n < ppem_pkg::NumSeq; n++) begin
      logic m;
      m = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if ((3'(i) < len) && (buf_bytes[i] != ppem_pkg::SEQ_BYTES[n][i])) begin
          m = 1'b0;
        end
      end
      complete[n] = m && (len == ppem_pkg::SEQ_LEN[n]);
      extend[n]   = m && (ppem_pkg::SEQ_LEN[n] > len);
    end
    stay = |(complete & ppem_pkg::SEQ_STAY);
  end

  always_comb begin
    push_o = 1'b0;
    cmd_o  = '0;
    held_d = held_q;
    cnt_d  = cnt_q;
    if (accept && !is_drop) begin
      if (is_cand && (|complete)) begin
        push_o      = 1'b1;
        cmd_o.mode  = 1'b1;
        cmd_o.stay  = stay;
        cmd_o.close = !stay && auto_close_q;
        cnt_d       = 2'd0;
      end else if (is_cand && (|extend)) begin
        held_d[cnt_q] = rx_byte_i;
        cnt_d         = cnt_q + 2'd1;
      end else begin
        push_o      = (cnt_q != 2'd0);
        cmd_o.cnt   = cnt_q;
        cmd_o.bytes = held_q;
        held_d[0]   = rx_byte_i;
        cnt_d       = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= 2'd0;
      auto_close_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        auto_close_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

`default_nettype wire

>>> rtl/ppem_queue.sv
// Command queue between the front end and the result sequencer.
`default_nettype none

module ppem_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ppem_pkg::cmd_t wdata_i,
  input  wire logic           pop_i,
  output ppem_pkg::cmd_t      rdata_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ppem_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> rtl/ppem_back.sv
// Back end: expand queued commands into result requests, one per cycle while out_stall_i is low.
`default_nettype none

module ppem_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ppem_pkg::cmd_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic                kind_o,
  output logic [7:0]          out_byte_o,
  output logic                stay_active_o,
  output logic                close_request_o,
  output logic                last_of_run_o
);

  logic       out_valid_q;
  logic [1:0] idx_q;
  logic       load;
  logic       last;
  logic       kind_q, stay_q, close_q, last_q;
  logic [7:0] byte_q;

  assign load  = !out_valid_q || !out_stall_i;
  assign last  = head_i.mode || (idx_q == head_i.cnt - 2'd1);
  assign pop_o = load && !empty_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      out_valid_q <= !empty_i;
      if (!empty_i) begin
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      kind_q  <= head_i.mode;
      byte_q  <= head_i.mode ? 8'h00 : head_i.bytes[idx_q];
      stay_q  <= head_i.stay;
      close_q <= head_i.close;
      last_q  <= last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign out_byte_o      = byte_q;
  assign stay_active_o   = stay_q;
  assign close_request_o = close_q;
  assign last_of_run_o   = last_q;

  a_idx_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> !empty_i)
    else $error("flush in progress without a queued command");

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> (!head_i.mode && (idx_q < head_i.cnt)))
    else $error("flush index outside held run");

  a_mode_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q) |-> (last_q && (byte_q == 8'h00)))
    else $error("mode result not a single clean request");

endmodule

`default_nettype wire

>>> rtl/printer_passthrough_exit_matcher.sv
// Top level: printer pass-through exit matcher.
// Accepts one byte per cycle while the command queue has room.
// A command is written into the queue on the accepting edge and leaves through the
// output register; one result request per cycle while out_stall_i is low, so a flush
// of n held bytes gives n result requests, a mode result one.
// Reset clears held count, queue, output valid and auto_close; held bytes are undefined.
`default_nettype none

module printer_passthrough_exit_matcher #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [7:0]       out_byte_o,
  output logic             stay_active_o,
  output logic             close_request_o,
  output logic             last_of_run_o
);

  ppem_pkg::cmd_t push_cmd;
  ppem_pkg::cmd_t head_cmd;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  assign in_stall_o = q_full;

  ppem_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  ppem_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ppem_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_cmd),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .out_byte_o      (out_byte_o),
    .stay_active_o   (stay_active_o),
    .close_request_o (close_request_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire
